[rtl/core/mcf_pkg.sv]
package mcf_pkg;

  localparam int unsigned FrameLen = 10;
  localparam int unsigned ByteIdxW = $clog2(FrameLen);

  // Request codes
  localparam logic [2:0] REQ_PLAY      = 3'd0;
  localparam logic [2:0] REQ_SET_VOL   = 3'd1;
  localparam logic [2:0] REQ_VOL_UP    = 3'd2;
  localparam logic [2:0] REQ_VOL_DOWN  = 3'd3;
  localparam logic [2:0] REQ_PAUSE     = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_PLAYER_READY  = 3'd0;
  localparam logic [2:0] CFG_GUARD_DEFAULT = 3'd1;
  localparam logic [2:0] CFG_GUARD_REPLY   = 3'd2;
  localparam logic [2:0] CFG_REPLY_TRACK   = 3'd3;
  localparam logic [2:0] CFG_URGENT_TRACK  = 3'd4;
  localparam logic [2:0] CFG_VOL_CEILING   = 3'd5;
  localparam logic [2:0] CFG_VOL_INCREMENT = 3'd6;

  // Frame bytes
  localparam logic [7:0] FRAME_START   = 8'h7E;
  localparam logic [7:0] FRAME_VERSION = 8'hFF;
  localparam logic [7:0] FRAME_LENGTH  = 8'h06;
  localparam logic [7:0] FRAME_END     = 8'hEF;

  // Command codes
  localparam logic [7:0] CMD_PLAY   = 8'h03;
  localparam logic [7:0] CMD_VOLUME = 8'h06;
  localparam logic [7:0] CMD_PAUSE  = 8'h0E;

  // Reset values
  localparam logic [15:0] RST_GUARD_DEFAULT = 16'd1800;
  localparam logic [15:0] RST_GUARD_REPLY   = 16'd4500;
  localparam logic [7:0]  RST_REPLY_TRACK   = 8'd2;
  localparam logic [7:0]  RST_URGENT_TRACK  = 8'd6;
  localparam logic [4:0]  RST_VOL_CEILING   = 5'd30;
  localparam logic [4:0]  RST_VOL_INCREMENT = 5'd3;
  localparam logic [4:0]  RST_VOLUME        = 5'd30;

  typedef struct packed {
    logic        player_ready;
    logic [15:0] guard_default;
    logic [15:0] guard_reply;
    logic [7:0]  reply_track;
    logic [7:0]  urgent_track;
    logic [4:0]  vol_ceiling;
    logic [4:0]  vol_increment;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] cmd;
    logic [7:0] arg;
  } frame_req_t;

endpackage

[rtl/core/mcf_ctrl.sv]
module mcf_ctrl
  import mcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        accept_i,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  track_number_i,
  input  logic [7:0]  volume_request_i,
  input  logic [31:0] now_tick_i,
  output frame_req_t  frame_req_o
);

  logic [31:0] guard_until_q, guard_until_d;
  logic [4:0]  volume_q, volume_d;

  logic [5:0]  vol_up_sum;
  logic [4:0]  vol_target;
  logic        vol_apply;
  logic        guard_busy;
  logic [15:0] guard_len;

  always_comb begin
    vol_up_sum = {1'b0, volume_q} + {1'b0, cfg_i.vol_increment};
    guard_busy = (track_number_i != cfg_i.urgent_track) && (now_tick_i < guard_until_q);
    guard_len  = (track_number_i == cfg_i.reply_track) ? cfg_i.guard_reply
                                                       : cfg_i.guard_default;
  end

  always_comb begin
    vol_apply = 1'b0;
    case (req_type_i)
      REQ_SET_VOL: begin
        vol_apply  = 1'b1;
        vol_target = (volume_request_i > {3'b000, cfg_i.vol_ceiling}) ?
                     cfg_i.vol_ceiling : volume_request_i[4:0];
      end
      REQ_VOL_UP: begin
        vol_apply  = 1'b1;
        vol_target = (vol_up_sum > {1'b0, cfg_i.vol_ceiling}) ?
                     cfg_i.vol_ceiling : vol_up_sum[4:0];
      end
      REQ_VOL_DOWN: begin
        vol_apply  = 1'b1;
        vol_target = (volume_q >= cfg_i.vol_increment) ?
                     (volume_q - cfg_i.vol_increment) : 5'd0;
        // a lowered ceiling can sit below the current volume
        if (vol_target > cfg_i.vol_ceiling) begin
          vol_target = cfg_i.vol_ceiling;
        end
      end
      default: begin
        vol_target = volume_q;
      end
    endcase
  end

  always_comb begin
    frame_req_o   = '0;
    guard_until_d = guard_until_q;
    volume_d      = volume_q;
    if (accept_i && cfg_i.player_ready) begin
      if (req_type_i == REQ_PLAY) begin
        if (!guard_busy) begin
          guard_until_d     = now_tick_i + {16'h0000, guard_len};
          frame_req_o.valid = 1'b1;
          frame_req_o.cmd   = CMD_PLAY;
          frame_req_o.arg   = track_number_i;
        end
      end else if (req_type_i == REQ_PAUSE) begin
        frame_req_o.valid = 1'b1;
        frame_req_o.cmd   = CMD_PAUSE;
        frame_req_o.arg   = 8'h00;
      end else if (vol_apply && (vol_target != volume_q)) begin
        volume_d          = vol_target;
        frame_req_o.valid = 1'b1;
        frame_req_o.cmd   = CMD_VOLUME;
        frame_req_o.arg   = {3'b000, vol_target};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_until_q <= '0;
      volume_q      <= RST_VOLUME;
    end else begin
      guard_until_q <= guard_until_d;
      volume_q      <= volume_d;
    end
  end

endmodule

[rtl/core/mcf_serializer.sv]
module mcf_serializer
  import mcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  frame_req_t frame_req_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_last_o
);

  // one waiting frame plus the one on the wire
  logic                pend_q, pend_d;
  logic [7:0]          pend_cmd_q, pend_arg_q;
  logic                act_q, act_d;
  logic [ByteIdxW-1:0] cnt_q, cnt_d;
  logic [7:0]          cmd_q, arg_q;
  logic [15:0]         chk_q;
  logic [15:0]         pend_sum;

  logic out_xfer, last, load;

  assign last     = (cnt_q == ByteIdxW'(FrameLen - 1));
  assign out_xfer = act_q && !out_stall_i;
  assign load     = pend_q && (!act_q || (out_xfer && last));
  assign full_o   = pend_q;

  assign pend_sum = {8'h00, FRAME_VERSION} + {8'h00, FRAME_LENGTH} +
                    {8'h00, pend_cmd_q} + {8'h00, pend_arg_q};

  always_comb begin
    pend_d = pend_q;
    if (load) begin
      pend_d = 1'b0;
    end
    if (frame_req_i.valid) begin
      pend_d = 1'b1;
    end
  end

  always_comb begin
    act_d = act_q;
    cnt_d = cnt_q;
    if (load) begin
      act_d = 1'b1;
      cnt_d = '0;
    end else if (out_xfer) begin
      if (last) begin
        act_d = 1'b0;
      end else begin
        cnt_d = cnt_q + ByteIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      act_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      act_q  <= act_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_req_i.valid) begin
      pend_cmd_q <= frame_req_i.cmd;
      pend_arg_q <= frame_req_i.arg;
    end
    if (load) begin
      cmd_q <= pend_cmd_q;
      arg_q <= pend_arg_q;
      chk_q <= 16'h0000 - pend_sum;
    end
  end

  always_comb begin
    case (cnt_q)
      4'd0:    frame_byte_o = FRAME_START;
      4'd1:    frame_byte_o = FRAME_VERSION;
      4'd2:    frame_byte_o = FRAME_LENGTH;
      4'd3:    frame_byte_o = cmd_q;
      4'd6:    frame_byte_o = arg_q;
      4'd7:    frame_byte_o = chk_q[15:8];
      4'd8:    frame_byte_o = chk_q[7:0];
      4'd9:    frame_byte_o = FRAME_END;
      default: frame_byte_o = 8'h00;
    endcase
  end

  assign out_valid_o  = act_q;
  assign frame_last_o = last;

endmodule

[rtl/core/mp3_module_command_framer.sv]
// Command framer for a serial MP3 player module.
//
// Input channel: one request per transfer (req_type_i, track_number_i,
// volume_request_i, now_tick_i), qualified by in_valid_i and held off by
// in_stall_o. Output channel: one frame byte per transfer on frame_byte_o,
// frame_last_o marks the tenth byte; out_stall_i from the receiver holds it.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must do so only while the block is idle (unchecked).
//
// A request is decided in the cycle it is accepted (guard and volume state
// update there). A sent request yields a ten-byte frame that is registered
// in the holding slot and then loaded into the byte serializer; bytes then
// go out one per cycle unless out_stall_i holds them. One frame waits in
// the holding slot while the previous one is on the wire, so in_stall_o
// rises only while that slot is occupied. A dropped request takes one
// input transfer and yields no frame.
// A receiver stall freezes the current byte and, once the slot is full,
// backs up to the input. Reset clears both slots, the guard time to zero,
// the volume to 30 and the registers to their defaults (player not ready).
module mp3_module_command_framer
  import mcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  track_number_i,
  input  logic [7:0]  volume_request_i,
  input  logic [31:0] now_tick_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o
);

  cfg_t       cfg_q, cfg_d;
  frame_req_t frame_req;
  logic       slot_full;
  logic       in_xfer;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PLAYER_READY:  cfg_d.player_ready  = cfg_data_i[0];
        CFG_GUARD_DEFAULT: cfg_d.guard_default = cfg_data_i;
        CFG_GUARD_REPLY:   cfg_d.guard_reply   = cfg_data_i;
        CFG_REPLY_TRACK:   cfg_d.reply_track   = cfg_data_i[7:0];
        CFG_URGENT_TRACK:  cfg_d.urgent_track  = cfg_data_i[7:0];
        CFG_VOL_CEILING:   cfg_d.vol_ceiling   = cfg_data_i[4:0];
        CFG_VOL_INCREMENT: cfg_d.vol_increment = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.player_ready  <= 1'b0;
      cfg_q.guard_default <= RST_GUARD_DEFAULT;
      cfg_q.guard_reply   <= RST_GUARD_REPLY;
      cfg_q.reply_track   <= RST_REPLY_TRACK;
      cfg_q.urgent_track  <= RST_URGENT_TRACK;
      cfg_q.vol_ceiling   <= RST_VOL_CEILING;
      cfg_q.vol_increment <= RST_VOL_INCREMENT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = slot_full;
  assign in_xfer    = in_valid_i && !slot_full;

  mcf_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .accept_i         (in_xfer),
    .req_type_i       (req_type_i),
    .track_number_i   (track_number_i),
    .volume_request_i (volume_request_i),
    .now_tick_i       (now_tick_i),
    .frame_req_o      (frame_req)
  );

  mcf_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_req_i  (frame_req),
    .full_o       (slot_full),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .frame_last_o (frame_last_o)
  );

endmodule

[rtl/core/mcf_checker.sv]
module mcf_checker
  import mcf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  frame_byte_o,
  input logic        frame_last_o
);

  logic                out_xfer;
  logic [ByteIdxW-1:0] pos_q;

  assign out_xfer = out_valid_o && !out_stall_i;

  // byte position inside the current frame, as seen on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (out_xfer) begin
      pos_q <= frame_last_o ? '0 : pos_q + ByteIdxW'(1);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o)
      && $stable(frame_last_o))
    else $error("stalled output byte changed");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (frame_last_o == (pos_q == ByteIdxW'(FrameLen - 1))))
    else $error("frame_last not on tenth byte");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && (pos_q == '0) |-> (frame_byte_o == FRAME_START))
    else $error("frame does not open with start byte");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && frame_last_o |-> (frame_byte_o == FRAME_END))
    else $error("frame does not close with end byte");

endmodule

bind mp3_module_command_framer mcf_checker u_mcf_checker (.*);

[tb/sv/mp3_module_command_framer_test.sv]
module mp3_module_command_framer_test;
  import mcf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  class frame_scoreboard;
    cfg_t        cfg;
    logic [31:0] guard_until;
    logic [4:0]  volume_now;
    frame_beat_t expected_bytes[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned bytes_checked;
    int unsigned frames_checked;

    function new();
      cfg = '{player_ready: 1'b0, guard_default: RST_GUARD_DEFAULT,
              guard_reply: RST_GUARD_REPLY, reply_track: RST_REPLY_TRACK,
              urgent_track: RST_URGENT_TRACK, vol_ceiling: RST_VOL_CEILING,
              vol_increment: RST_VOL_INCREMENT};
      guard_until = '0;
      volume_now = RST_VOLUME;
      mismatches = 0;
      requests = 0;
      bytes_checked = 0;
      frames_checked = 0;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void push_frame(logic [7:0] cmd, logic [7:0] arg);
      logic [15:0] sum;
      logic [15:0] chk;
      logic [7:0]  bytes[10];
      sum = 16'(FRAME_VERSION) + 16'(FRAME_LENGTH) + 16'(cmd) + 16'(arg);
      chk = 16'h0000 - sum;
      bytes = '{FRAME_START, FRAME_VERSION, FRAME_LENGTH, cmd, 8'h00,
                8'h00, arg, chk[15:8], chk[7:0], FRAME_END};
      foreach (bytes[i]) expected_bytes.push_back('{bytes[i], i == FrameLen - 1});
    endfunction

    function void push_volume(int unsigned level);
      if (level > cfg.vol_ceiling) level = cfg.vol_ceiling;
      if (level[4:0] == volume_now) return;
      volume_now = level[4:0];
      push_frame(CMD_VOLUME, 8'(volume_now));
    endfunction

    function void note_request(logic [2:0] req, logic [7:0] track, logic [7:0] vreq,
                               logic [31:0] now);
      int unsigned target;
      requests++;
      if (!cfg.player_ready) return;
      case (req)
        REQ_PLAY: begin
          // the urgent track ignores the guard
          if (track != cfg.urgent_track && now < guard_until) return;
          guard_until = now + ((track == cfg.reply_track) ? 32'(cfg.guard_reply)
                                                          : 32'(cfg.guard_default));
          push_frame(CMD_PLAY, track);
        end
        REQ_SET_VOL: push_volume(vreq);
        REQ_VOL_UP: begin
          target = volume_now + cfg.vol_increment;
          if (target > cfg.vol_ceiling) target = cfg.vol_ceiling;
          push_volume(target);
        end
        REQ_VOL_DOWN: begin
          target = (volume_now >= cfg.vol_increment) ? volume_now - cfg.vol_increment : 0;
          push_volume(target);
        end
        REQ_PAUSE: push_frame(CMD_PAUSE, 8'h00);
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      frame_beat_t exp_beat;
      bytes_checked++;
      if (last) frames_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected frame byte %h (last %b)", data, last);
        mismatches++;
        return;
      end
      exp_beat = expected_bytes.pop_front();
      if (data !== exp_beat.data) begin
        $error("frame_byte: expected %h, got %h", exp_beat.data, data);
        mismatches++;
      end
      if (last !== exp_beat.last) begin
        $error("frame_last: expected %b, got %b", exp_beat.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  req_type_i;
  logic [7:0]  track_number_i;
  logic [7:0]  volume_request_i;
  logic [31:0] now_tick_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  frame_byte_o;
  logic        frame_last_o;

  frame_scoreboard sb;
  bit              quiet_phase;
  logic [31:0]     tick_now;
  int unsigned     settings_used;

  mp3_module_command_framer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .track_number_i   (track_number_i),
    .volume_request_i (volume_request_i),
    .now_tick_i       (now_tick_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_byte_o     (frame_byte_o),
    .frame_last_o     (frame_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(logic [2:0] req, logic [7:0] track, logic [7:0] vreq,
                              logic [31:0] now);
    int unsigned gap;
    bit          accepted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= req;
    track_number_i   <= track;
    volume_request_i <= vreq;
    now_tick_i       <= now;
    do begin
      @(negedge clk_i);
      accepted = in_valid_i && !in_stall_o;
      @(posedge clk_i);
    end while (!accepted);
    sb.note_request(req, track, vreq, now);
  endtask

  // drain all frames, then allow for a dropped request still in flight
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(CFG_PLAYER_READY, 16'(c.player_ready));
    write_reg(CFG_GUARD_DEFAULT, c.guard_default);
    write_reg(CFG_GUARD_REPLY, c.guard_reply);
    write_reg(CFG_REPLY_TRACK, 16'(c.reply_track));
    write_reg(CFG_URGENT_TRACK, 16'(c.urgent_track));
    write_reg(CFG_VOL_CEILING, 16'(c.vol_ceiling));
    write_reg(CFG_VOL_INCREMENT, 16'(c.vol_increment));
    cfg_we_i <= 1'b0;
    sb.cfg = c;
    settings_used++;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.player_ready  = 1'b1;
    c.guard_default = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
    c.guard_reply   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6000));
    c.reply_track   = 8'($urandom);
    c.urgent_track  = 8'($urandom);
    c.vol_ceiling   = 5'($urandom_range(0, 31));
    c.vol_increment = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 5));
    return c;
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned r;
    int unsigned span;
    logic [2:0]  req;
    logic [7:0]  track;
    logic [7:0]  vreq;
    repeat (count) begin
      r = $urandom_range(0, 19);
      if (r < 8) req = REQ_PLAY;
      else if (r < 11) req = REQ_SET_VOL;
      else if (r < 14) req = REQ_VOL_UP;
      else if (r < 17) req = REQ_VOL_DOWN;
      else if (r < 19) req = REQ_PAUSE;
      else req = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 9);
      if (r < 3) track = sb.cfg.reply_track;
      else if (r < 5) track = sb.cfg.urgent_track;
      else track = 8'($urandom);
      vreq = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31)) : 8'($urandom);
      // advance the tick so that the guard sometimes holds and sometimes expires
      span = sb.cfg.guard_default + 16;
      if ($urandom_range(0, 9) == 0) tick_now = $urandom;
      else tick_now = tick_now + $urandom_range(0, span / 2);
      send_request(req, track, vreq, tick_now);
    end
  endtask

  initial begin
    int unsigned stall_run;
    bit          stall_on;
    bit          fire;
    logic [7:0]  data;
    logic        last;
    stall_run = 0;
    stall_on = 1'b0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      fire = out_valid_o && !out_stall_i;
      data = frame_byte_o;
      last = frame_last_o;
      @(posedge clk_i);
      if (fire) sb.check_byte(data, last);
      if (stall_run == 0) begin
        if (quiet_phase || $urandom_range(0, 9) < 7) begin
          stall_on = 1'b0;
          stall_run = $urandom_range(1, 8);
        end else begin
          stall_on = 1'b1;
          stall_run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end
      stall_run--;
      out_stall_i <= stall_on;
    end
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    cfg_t c;
    sb = new();
    quiet_phase = 1'b0;
    settings_used = 0;
    tick_now = '0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_PLAYER_READY;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    req_type_i       <= REQ_PLAY;
    track_number_i   <= '0;
    volume_request_i <= '0;
    now_tick_i       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // player not ready after reset: all dropped
    send_request(REQ_PAUSE, 8'd0, 8'd0, 32'd0);
    send_request(REQ_PLAY, 8'd1, 8'd0, 32'd0);
    send_request(REQ_SET_VOL, 8'd0, 8'd5, 32'd0);
    wait_idle();

    c = sb.cfg;
    c.player_ready = 1'b1;
    apply_config(c);
    send_request(REQ_PAUSE, 8'd0, 8'd0, 32'd0);
    send_request(REQ_PLAY, 8'd0, 8'd0, 32'd0);
    send_request(REQ_PLAY, 8'd255, 8'd0, 32'd100);       // guard holds
    send_request(REQ_PLAY, 8'd6, 8'd0, 32'd200);         // urgent bypasses guard
    send_request(REQ_PLAY, 8'd2, 8'd0, 32'd2000);        // reply track, long guard
    send_request(REQ_PLAY, 8'd9, 8'd0, 32'd6499);
    send_request(REQ_PLAY, 8'd9, 8'd0, 32'd6500);
    send_request(REQ_SET_VOL, 8'd0, 8'd255, 32'd0);      // clamps to the ceiling, which is the current level
    send_request(REQ_SET_VOL, 8'd0, 8'd0, 32'd0);
    send_request(REQ_VOL_DOWN, 8'd0, 8'd0, 32'd0);       // floor at zero
    send_request(REQ_VOL_UP, 8'd0, 8'd0, 32'd0);
    send_request(REQ_SET_VOL, 8'd0, 8'd29, 32'd0);
    send_request(REQ_VOL_UP, 8'd0, 8'd0, 32'd0);         // clamps at ceiling
    send_request(REQ_VOL_UP, 8'd0, 8'd0, 32'd0);
    send_request(3'd5, 8'hAA, 8'h55, 32'h5555_AAAA);
    send_request(3'd6, 8'h55, 8'hAA, 32'hAAAA_5555);
    send_request(3'd7, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_request(REQ_PLAY, 8'hFF, 8'd0, 32'hFFFF_FFFF);  // guard end wraps
    send_request(REQ_PLAY, 8'd1, 8'd0, 32'd0);
    send_request(REQ_PAUSE, 8'd0, 8'd0, 32'd0);

    for (int p = 0; p < 9; p++) begin
      wait_idle();
      quiet_phase = ($urandom_range(0, 3) == 0);
      case (p)
        0: c = '{1'b1, 16'h0000, 16'hFFFF, 8'hFF, 8'h00, 5'd31, 5'd31};
        1: c = '{1'b1, 16'hFFFF, 16'h0000, 8'h00, 8'hFF, 5'd0, 5'd0};
        2: begin
          c = random_config();
          c.player_ready = 1'b0;
        end
        default: c = random_config();
      endcase
      apply_config(c);
      run_random((p == 2) ? 8 : 26);
    end

    quiet_phase = 1'b0;
    wait_idle();
    $display("Checked %0d frame bytes in %0d frames from %0d requests",
             sb.bytes_checked, sb.frames_checked, sb.requests);
    $display("Register settings applied: %0d, mismatches: %0d", settings_used, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
